// ===== rtl/cartesian_to_cylindrical_defines.svh =====
// Assertion macros used by the converter top level.
`ifndef CARTESIAN_TO_CYLINDRICAL_DEFINES_SVH
`define CARTESIAN_TO_CYLINDRICAL_DEFINES_SVH
`ifndef SYNTH
// Check prop at every rising clock edge outside reset.
`define CTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that cond never holds outside reset.
`define CTC_ASSERT_NEVER(lbl, cond, msg) `CTC_ASSERT(lbl, !(cond), msg)
`else
`define CTC_ASSERT(lbl, prop, msg)
`define CTC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/ctc_pkg.sv =====
// Types, constants and the arctangent table of the Cartesian to cylindrical converter.
`timescale 1ns / 1ps
`default_nettype none
package ctc_pkg;

	localparam int DIMENSION_DEF     = 3;
	localparam int CORDIC_STAGES_DEF = 24;

	localparam int COORD_W    = 24;
	localparam int GUARD_BITS = 6;
	localparam int CX_W       = 32;   // rotation vector width, holds gain growth
	localparam int ANG_W      = 33;   // signed angle, radians * 2^30
	localparam int FULL_W     = 33;   // unsigned angle over the full turn
	localparam int PROD_W     = 63;
	localparam int RAD_SHIFT  = 32 + GUARD_BITS;
	localparam int AZ_SHIFT   = 9;

	localparam logic [FULL_W-1:0] PI_Q30      = 33'd3373259426;
	localparam logic [FULL_W-1:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [FULL_W-1:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [FULL_W-1:0] AZ_ROUND    = 33'd256;

	localparam logic [COORD_W-1:0] AZ_ZERO          = 24'd0;
	localparam logic [COORD_W-1:0] AZ_PI            = 24'd6588397;
	localparam logic [COORD_W-1:0] AZ_HALF_PI       = 24'd3294199;
	localparam logic [COORD_W-1:0] AZ_THREE_HALF_PI = 24'd9882596;
	localparam logic [COORD_W-1:0] AZ_FULL_TURN     = 24'd13176795;
	localparam logic [COORD_W-1:0] RAD_MAX          = 24'hFFFFFF;

	localparam logic [31:0]       INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [PROD_W-1:0] RAD_ROUND    = PROD_W'(64'd1 << (RAD_SHIFT - 1));

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
	} in_t;

	typedef struct packed {
		logic        [COORD_W-1:0] azimuth;
		logic        [COORD_W-1:0] radius;
		logic signed [COORD_W-1:0] height;
	} out_t;

	// Rotation vector and angle accumulator.
	typedef struct packed {
		logic signed [CX_W-1:0]  cx;
		logic signed [CX_W-1:0]  cy;
		logic signed [ANG_W-1:0] ang;
	} rot_t;

	// Side information that rides along the rotation chain.
	typedef struct packed {
		logic                      special;
		logic                      x_pos;
		logic                      y_pos;
		logic        [COORD_W-1:0] spec_az;
		logic        [COORD_W-1:0] spec_rad;
		logic signed [COORD_W-1:0] z;
	} side_t;

	// floor(atan(2^-i) * 2^30)
	function automatic logic [ANG_W-1:0] ctc_atan(input int i);
		logic [ANG_W-1:0] r;
		case (i)
			0: r = 33'd843314856;
			1: r = 33'd497837829;
			2: r = 33'd263043836;
			3: r = 33'd133525158;
			4: r = 33'd67021686;
			5: r = 33'd33543515;
			6: r = 33'd16775850;
			7: r = 33'd8388437;
			8: r = 33'd4194282;
			9: r = 33'd2097149;
			default: begin
				if (i <= 30) r = ANG_W'((64'd1 << (30 - i)) - 64'd1);
				else r = '0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cartesian_to_cylindrical.sv =====
// Top level of the pipelined Cartesian to cylindrical converter.
//
//  channel   signals              transfer condition       payload
//  -------   -------------------  -----------------------  --------------------------
//  command   start, busy, cmd     start && !busy at clk    x_coord, y_coord, z_coord
//  result    done, result         done at clk, one cycle   azimuth, radius, height
//
// One point enters per cycle; busy stays low because nothing downstream can stall.
// Pipeline registers: one capture stage (absolute values, axis
// detection), one register per CORDIC micro-rotation, one stage for quadrant
// placement and the gain multiply, one stage for rounding and the output register.
// Reset clears only the valid bits; data registers load freely and are
// qualified by them.
`timescale 1ns / 1ps
`default_nettype none
`include "cartesian_to_cylindrical_defines.svh"
module cartesian_to_cylindrical #(
	parameter int DIMENSION     = ctc_pkg::DIMENSION_DEF,
	parameter int CORDIC_STAGES = ctc_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ctc_pkg::in_t  cmd,
	output logic          done,
	output ctc_pkg::out_t result
);
	import ctc_pkg::*;

	localparam int LAT = CORDIC_STAGES + 3;

	// ---------------- capture stage ----------------
	logic                accept;
	logic [COORD_W-1:0]  ax;
	logic [COORD_W-1:0]  ay;
	logic                x_zero;
	logic                y_zero;
	rot_t                rot_in;
	side_t               side_in;

	logic                valid_s1;
	rot_t                rot_s1;
	side_t               side_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		// two's complement magnitude; the most negative code maps to 2^23 unsigned
		ax     = cmd.x_coord[COORD_W-1] ? COORD_W'(-cmd.x_coord) : cmd.x_coord;
		ay     = cmd.y_coord[COORD_W-1] ? COORD_W'(-cmd.y_coord) : cmd.y_coord;
		x_zero = (cmd.x_coord == '0);
		y_zero = (cmd.y_coord == '0);

		rot_in.cx  = $signed({{(CX_W - COORD_W - GUARD_BITS){1'b0}}, ax, {GUARD_BITS{1'b0}}});
		rot_in.cy  = $signed({{(CX_W - COORD_W - GUARD_BITS){1'b0}}, ay, {GUARD_BITS{1'b0}}});
		rot_in.ang = '0;

		side_in.special = x_zero || y_zero;
		side_in.x_pos   = !cmd.x_coord[COORD_W-1] && !x_zero;
		side_in.y_pos   = !cmd.y_coord[COORD_W-1] && !y_zero;
		// axis points and the origin bypass the rotation chain
		if (x_zero && y_zero) side_in.spec_az = AZ_ZERO;
		else if (x_zero) side_in.spec_az = side_in.y_pos ? AZ_HALF_PI : AZ_THREE_HALF_PI;
		else side_in.spec_az = side_in.x_pos ? AZ_ZERO : AZ_PI;
		side_in.spec_rad = x_zero ? ay : ax;
		side_in.z        = (DIMENSION == 3) ? cmd.z_coord : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		rot_s1  <= rot_in;
		side_s1 <= side_in;
	end

	// ---------------- rotation chain ----------------
	logic  chain_valid [0:CORDIC_STAGES];
	rot_t  chain_rot   [0:CORDIC_STAGES];
	side_t chain_side  [0:CORDIC_STAGES];

	assign chain_valid[0] = valid_s1;
	assign chain_rot[0]   = rot_s1;
	assign chain_side[0]  = side_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		ctc_cordic_stage #(
			.STAGE (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[g]),
			.in_rot    (chain_rot[g]),
			.in_side   (chain_side[g]),
			.out_valid (chain_valid[g+1]),
			.out_rot   (chain_rot[g+1]),
			.out_side  (chain_side[g+1])
		);
	end

	// ---------------- quadrant and gain stage (s2, after the chain) ----------------
	rot_t                 rot_end;
	logic [FULL_W-1:0]    ang_c;
	logic [FULL_W-1:0]    full;
	logic [CX_W-2:0]      cx_u;
	logic [PROD_W-1:0]    prod;

	logic                 valid_s2;
	logic [FULL_W-1:0]    full_s2;
	logic [PROD_W-1:0]    prod_s2;
	side_t                side_s2;

	always_comb begin
		rot_end = chain_rot[CORDIC_STAGES];
		// clamp the residue of the angle into the first quadrant
		if (rot_end.ang[ANG_W-1]) ang_c = '0;
		else if (rot_end.ang > $signed(HALF_PI_Q30)) ang_c = HALF_PI_Q30;
		else ang_c = FULL_W'(rot_end.ang);

		if (chain_side[CORDIC_STAGES].x_pos)
			full = chain_side[CORDIC_STAGES].y_pos ? ang_c : TWO_PI_Q30 - ang_c;
		else
			full = chain_side[CORDIC_STAGES].y_pos ? PI_Q30 - ang_c : PI_Q30 + ang_c;

		// cx stays positive in vectoring mode
		cx_u = rot_end.cx[CX_W-2:0];
		prod = PROD_W'(cx_u) * PROD_W'(INV_GAIN_Q32);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else valid_s2 <= chain_valid[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		full_s2 <= full;
		prod_s2 <= prod;
		side_s2 <= chain_side[CORDIC_STAGES];
	end

	// ---------------- rounding and output stage (s3) ----------------
	logic [FULL_W-1:0]            az_sum;
	logic [COORD_W-1:0]           az_r;
	logic [PROD_W-1:0]            rad_sum;
	logic [PROD_W-RAD_SHIFT-1:0]  rad_wide;
	out_t                         res;

	logic                         valid_s3;
	out_t                         result_s3;

	always_comb begin
		az_sum   = full_s2 + AZ_ROUND;
		az_r     = az_sum[AZ_SHIFT +: COORD_W];
		rad_sum  = prod_s2 + RAD_ROUND;
		rad_wide = rad_sum[PROD_W-1:RAD_SHIFT];

		if (side_s2.special) begin
			res.azimuth = side_s2.spec_az;
			res.radius  = side_s2.spec_rad;
		end else begin
			// a full turn wraps back to zero
			res.azimuth = (az_r >= AZ_FULL_TURN) ? AZ_ZERO : az_r;
			res.radius  = (rad_wide > {1'b0, RAD_MAX}) ? RAD_MAX
			              : rad_wide[COORD_W-1:0];
		end
		res.height = side_s2.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		result_s3 <= res;
	end

	assign done   = valid_s3;
	assign result = result_s3;

	// ---------------- checks ----------------
	`CTC_ASSERT(a_done_latency, done |-> $past(start, LAT), "result without a command transfer")
	`CTC_ASSERT(a_az_range, done |-> (result.azimuth < AZ_FULL_TURN), "azimuth past full turn")
	`CTC_ASSERT(a_height, done |-> (result.height == $past(side_in.z, LAT)), "height mismatch")

endmodule
`default_nettype wire

// ===== rtl/ctc_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation.
`timescale 1ns / 1ps
`default_nettype none
module ctc_cordic_stage #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ctc_pkg::rot_t  in_rot,
	input  ctc_pkg::side_t in_side,
	output logic           out_valid,
	output ctc_pkg::rot_t  out_rot,
	output ctc_pkg::side_t out_side
);
	import ctc_pkg::*;

	localparam logic [ANG_W-1:0] ATAN = ctc_atan(STAGE);

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	rot_t                   nxt;
	logic                   cor_valid_s1;
	rot_t                   cor_rot_s1;
	side_t                  cor_side_s1;

	always_comb begin
		dx = in_rot.cy >>> STAGE;
		dy = in_rot.cx >>> STAGE;
		// rotate toward the x axis by the sign of y
		if (!in_rot.cy[CX_W-1]) begin
			nxt.cx  = in_rot.cx + dx;
			nxt.cy  = in_rot.cy - dy;
			nxt.ang = in_rot.ang + $signed(ATAN);
		end else begin
			nxt.cx  = in_rot.cx - dx;
			nxt.cy  = in_rot.cy + dy;
			nxt.ang = in_rot.ang - $signed(ATAN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_valid_s1 <= 1'b0;
		else cor_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		cor_rot_s1  <= nxt;
		cor_side_s1 <= in_side;
	end

	assign out_valid = cor_valid_s1;
	assign out_rot   = cor_rot_s1;
	assign out_side  = cor_side_s1;

endmodule
`default_nettype wire

// ===== test/ctc_checker.sv =====
// Checker for the Cartesian to cylindrical converter: predicts and compares every result.
`timescale 1ns / 1ps
module ctc_checker #(
	parameter int DIMENSION     = ctc_pkg::DIMENSION_DEF,
	parameter int CORDIC_STAGES = ctc_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  ctc_pkg::in_t  cmd,
	input  logic          done,
	input  ctc_pkg::out_t result,
	output int            mismatches,
	output int            pending
);
	import ctc_pkg::*;

	out_t cyl_q[$];

	// floor(atan(2^-i) * 2^30)
	function automatic longint micro_angle(int i);
		case (i)
			0: return 843314856;
			1: return 497837829;
			2: return 263043836;
			3: return 133525158;
			4: return 67021686;
			5: return 33543515;
			6: return 16775850;
			7: return 8388437;
			8: return 4194282;
			9: return 2097149;
			default: return (i <= 30) ? (longint'(1) << (30 - i)) - 1 : 0;
		endcase
	endfunction

	function automatic out_t to_cylindrical(in_t p);
		longint x, y, cx, cy, dx, dy, ang, full, az;
		longint half_pi, pi_q, two_pi;
		longint unsigned prod, rad;
		out_t r;
		x = longint'(p.x_coord);
		y = longint'(p.y_coord);
		half_pi = longint'(HALF_PI_Q30);
		pi_q = longint'(PI_Q30);
		two_pi = longint'(TWO_PI_Q30);
		r = '0;
		if (x == 0 && y == 0) begin
			r.azimuth = AZ_ZERO;
			r.radius = '0;
		end else if (x == 0) begin
			r.azimuth = (y > 0) ? AZ_HALF_PI : AZ_THREE_HALF_PI;
			r.radius = COORD_W'((y < 0) ? -y : y);
		end else if (y == 0) begin
			r.azimuth = (x > 0) ? AZ_ZERO : AZ_PI;
			r.radius = COORD_W'((x < 0) ? -x : x);
		end else begin
			cx = ((x < 0) ? -x : x) << GUARD_BITS;
			cy = ((y < 0) ? -y : y) << GUARD_BITS;
			ang = 0;
			for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx += dx;
					cy -= dy;
					ang += micro_angle(i);
				end else begin
					cx -= dx;
					cy += dy;
					ang -= micro_angle(i);
				end
			end
			if (ang < 0) ang = 0;
			if (ang > half_pi) ang = half_pi;
			if (x > 0) full = (y > 0) ? ang : two_pi - ang;
			else full = (y > 0) ? pi_q - ang : pi_q + ang;
			az = (full + 256) >> AZ_SHIFT;
			if (az >= longint'(AZ_FULL_TURN)) az = 0;
			r.azimuth = COORD_W'(az);
			prod = longint'(cx) * longint'(INV_GAIN_Q32);
			rad = (prod + (64'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT;
			if (rad > 64'hFFFFFF) rad = 64'hFFFFFF;
			r.radius = COORD_W'(rad);
		end
		r.height = (DIMENSION == 3) ? p.z_coord : '0;
		return r;
	endfunction

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (start && !busy) cyl_q.push_back(to_cylindrical(cmd));
			if (done) begin
				if (cyl_q.size() == 0) begin
					$error("result with no point outstanding: az %0d rad %0d h %0d",
						result.azimuth, result.radius, result.height);
					mismatches <= mismatches + 1;
				end else begin
					want = cyl_q.pop_front();
					if (result != want) mismatches <= mismatches + 1;
					if (result.azimuth != want.azimuth)
						$error("azimuth: expected %0d, got %0d", want.azimuth, result.azimuth);
					if (result.radius != want.radius)
						$error("radius: expected %0d, got %0d", want.radius, result.radius);
					if (result.height != want.height)
						$error("height: expected %0d, got %0d", want.height, result.height);
				end
			end
			pending <= cyl_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Top of the converter testbench: clock, reset, point stimulus and the verdict.
`timescale 1ns / 1ps
module tb;
	import ctc_pkg::*;

	localparam int DIMENSION     = DIMENSION_DEF;
	localparam int CORDIC_STAGES = CORDIC_STAGES_DEF;
	// Pipeline depth from the block's header, plus some slack.
	localparam int DRAIN_CYCLES  = CORDIC_STAGES + 3 + 10;
	localparam int PHASE_POINTS  = 260;

	localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_t  cmd;
	logic done;
	out_t result;
	int   mismatches;
	int   pending;

	cartesian_to_cylindrical #(
		.DIMENSION    (DIMENSION),
		.CORDIC_STAGES(CORDIC_STAGES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	ctc_checker #(
		.DIMENSION    (DIMENSION),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Pack one point.
	function automatic in_t point(int x, int y, int z);
		in_t p;
		p.x_coord = COORD_W'(x);
		p.y_coord = COORD_W'(y);
		p.z_coord = COORD_W'(z);
		return p;
	endfunction

	// One of the values where the arithmetic is most likely to break.
	function automatic int corner_value();
		case ($urandom_range(4))
			0: return -(1 << 23);
			1: return (1 << 23) - 1;
			2: return 0;
			3: return 1;
			default: return -1;
		endcase
	endfunction

	function automatic int signed_small(int mag);
		int v;
		v = $urandom_range(mag);
		return $urandom_range(1) ? -v : v;
	endfunction

	// Draw a point: half full range, the rest small values, axes, corners,
	// near-axis and diagonal points so every quadrant rule gets exercised.
	function automatic in_t random_point();
		int x, y, z, m;
		z = $urandom;
		x = $urandom;
		y = $urandom;
		case ($urandom_range(9))
			5: begin
				x = signed_small(255);
				y = signed_small(255);
			end
			6: begin
				if ($urandom_range(1)) x = 0;
				else y = 0;
			end
			7: begin
				x = corner_value();
				y = corner_value();
			end
			8: begin
				// Tiny coordinate against a large one: angles near an axis
				// and the full-turn wrap.
				if ($urandom_range(1)) y = signed_small(3);
				else x = signed_small(3);
			end
			9: begin
				m = $urandom_range((1 << 23) - 1);
				x = $urandom_range(1) ? -m : m;
				y = $urandom_range(1) ? -m : m;
			end
			default: ;
		endcase
		return point(x, y, z);
	endfunction

	// Transfer one point, idling first with the given odds.
	task automatic send(input in_t p, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase(input int n, input int idle_pct);
		for (int k = 0; k < n; k++) send(random_point(), idle_pct);
	endtask

	initial begin
		in_t directed[$];
		arst_n = 1'b0;
		start <= 1'b0;
		cmd <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Origin, both axes in both directions.
		directed.push_back(point(0, 0, 5));
		directed.push_back(point(0, 100, -1));
		directed.push_back(point(0, -100, 0));
		directed.push_back(point(100, 0, C_MAX));
		directed.push_back(point(-100, 0, C_MIN));
		// Corners of the input range, including the most negative value.
		directed.push_back(point(C_MAX, C_MAX, 1));
		directed.push_back(point(C_MIN, C_MIN, -2));
		directed.push_back(point(C_MIN, C_MAX, 3));
		directed.push_back(point(C_MAX, C_MIN, 4));
		directed.push_back(point(C_MIN, 0, 7));
		directed.push_back(point(0, C_MIN, 8));
		directed.push_back(point(C_MAX, 0, 9));
		directed.push_back(point(0, C_MAX, 10));
		// Tiny coordinate against a large one; with tiny negative y and large x the azimuth wraps past the full turn.
		directed.push_back(point(C_MAX, -1, 11));
		directed.push_back(point(C_MIN, -1, 12));
		directed.push_back(point(C_MIN, 1, 13));
		directed.push_back(point(1, C_MAX, 14));
		// Unit diagonals in each quadrant, then 3-4 points in the first and third quadrants.
		directed.push_back(point(1, 1, 15));
		directed.push_back(point(-1, 1, 16));
		directed.push_back(point(-1, -1, 17));
		directed.push_back(point(1, -1, 18));
		directed.push_back(point(3, 4, 19));
		directed.push_back(point(-3, -4, 20));
		foreach (directed[k]) send(directed[k], 0);
		drain();

		random_phase(PHASE_POINTS, 28);
		drain();
		random_phase(PHASE_POINTS, 48);
		drain();
		// Back-to-back transfers, no gaps at all.
		random_phase(PHASE_POINTS, 0);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
